### src/wse_pkg.sv
// Shared constants, types and lookup functions for the WAV sample extractor.
`timescale 1ns / 1ps
package wse_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W = $clog2(MAX_CHANNELS);
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

  // parse phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_CHUNK_HDR = 3'd1;
  localparam logic [2:0] PH_FMT = 3'd2;
  localparam logic [2:0] PH_SKIP = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_SINK = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER = 3'd1;
  localparam logic [2:0] ST_BAD_TAG = 3'd2;
  localparam logic [2:0] ST_BAD_DEPTH = 3'd3;
  localparam logic [2:0] ST_NO_DATA = 3'd4;
  localparam logic [2:0] ST_BAD_CHAN = 3'd5;

  localparam logic [31:0] TAG_FMT = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam logic [15:0] FMT_PCM = 16'h0001;
  localparam logic [15:0] FMT_FLOAT = 16'h0003;
  localparam logic [15:0] FMT_EXT = 16'hFFFE;
  localparam logic [31:0] DEF_RATE = 32'd44100;

  typedef logic [MAX_CHANNELS-1:0][31:0] frame_t;

  // parser -> emitter events
  typedef struct packed {
    logic        frame_valid;
    frame_t      frame;
    logic [CNT_W-1:0] frame_count;
    logic        status_valid;
    logic [2:0]  status_code;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] bits_per_sample;
    logic        float_format;
  } evt_t;

  // emitter -> parser occupancy
  typedef struct packed {
    logic frame_pend;
    logic status_pend;
  } occ_t;

  // expected header byte; bytes 4..7 (RIFF size) are free
  function automatic logic [7:0] hdr_byte(input logic [3:0] p);
    logic [7:0] r;
    unique case (p)
      4'd0: r = 8'h52;
      4'd1: r = 8'h49;
      4'd2: r = 8'h46;
      4'd3: r = 8'h46;
      4'd8: r = 8'h57;
      4'd9: r = 8'h41;
      4'd10: r = 8'h56;
      4'd11: r = 8'h45;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // IEEE float subformat GUID
  function automatic logic [7:0] guid_byte(input logic [3:0] i);
    logic [7:0] r;
    unique case (i)
      4'd0: r = 8'h03;
      4'd6: r = 8'h10;
      4'd8: r = 8'h80;
      4'd11: r = 8'hAA;
      4'd13: r = 8'h38;
      4'd14: r = 8'h9B;
      4'd15: r = 8'h71;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

### src/wse_if.sv
// Valid/ready channel interfaces for file bytes and result items.
`timescale 1ns / 1ps
interface wse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface wse_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic signed [31:0] sample_value;
  logic [2:0]  channel_index;
  logic        frame_end;
  logic [2:0]  status_code;
  logic [31:0] sample_rate;
  logic [15:0] channel_count;
  logic [15:0] bits_per_sample;
  logic        float_format;
  modport source (output valid, kind, sample_value, channel_index, frame_end, status_code,
                  sample_rate, channel_count, bits_per_sample, float_format, input ready);
  modport sink (input valid, kind, sample_value, channel_index, frame_end, status_code,
                sample_rate, channel_count, bits_per_sample, float_format, output ready);
endinterface

### src/wse_conv.sv
// Sample conversion of an assembled little-endian word to Q1.31.
`timescale 1ns / 1ps
module wse_conv import wse_pkg::*; (
  input  logic [31:0] raw,
  input  logic [15:0] depth,
  input  logic        is_float,
  output logic [31:0] q31
);

  logic        neg;
  logic [7:0]  ex;
  logic [22:0] fr;
  logic [23:0] mant;
  logic [31:0] mag;
  logic [7:0]  rs;
  logic [7:0]  ls;
  logic [31:0] fq;

  always_comb begin
    neg = raw[31];
    ex = raw[30:23];
    fr = raw[22:0];
    mant = {1'b1, fr};
    rs = 8'd119 - ex;
    ls = ex - 8'd119;
    if (ex >= 8'd119) begin
      mag = {8'h00, mant} << ls[2:0];   // ex 119..126 -> shift 0..7
    end else if (rs >= 8'd32) begin
      mag = '0;
    end else begin
      mag = {8'h00, mant} >> rs[4:0];
    end
    priority if (ex == 8'hFF && fr != '0) begin
      fq = '0;                           // NaN
    end else if (ex >= 8'd127) begin
      fq = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (ex == 8'd0) begin
      fq = '0;
    end else begin
      fq = neg ? (32'd0 - mag) : mag;
    end
    priority if (is_float && depth == 16'd32) begin
      q31 = fq;
    end else if (depth == 16'd16) begin
      q31 = {raw[15:0], 16'h0000};
    end else if (depth == 16'd24) begin
      q31 = {raw[23:0], 8'h00};
    end else begin
      q31 = raw;
    end
  end

endmodule

### src/wse_parser.sv
// Byte-level RIFF/WAVE parser: header, chunk walk, fmt fields, sample assembly.
`timescale 1ns / 1ps
module wse_parser import wse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  wse_in_if.sink   byte_in,
  input  occ_t     occ,
  output evt_t     evt
);

  logic [2:0]  phase, phase_next;
  logic [31:0] pos, pos_next;
  logic [31:0] tag, tag_next;
  logic [31:0] len, len_next;
  logic [15:0] fmt_tag, fmt_tag_next;
  logic [15:0] chans, chans_next;
  logic [31:0] rate, rate_next;
  logic [15:0] depth, depth_next;
  logic        is_float, is_float_next;
  logic        guid_ok, guid_ok_next;
  logic [31:0] asm_word, asm_word_next;
  logic [1:0]  sbi, sbi_next;
  logic [CH_W-1:0] fci, fci_next;
  logic [31:0] frame_store [MAX_CHANNELS];

  logic        accept;
  logic [7:0]  b;
  logic [1:0]  nb1;
  logic [31:0] asm_full;
  logic [31:0] conv;
  logic        store_we;
  logic        may_complete;
  logic [15:0] fci_inc;
  logic [31:0] len_base;
  logic        bad;
  logic        stat_v;
  logic [2:0]  stat_code;
  logic        frm_v;

  assign b = byte_in.data_byte;
  assign nb1 = (depth == 16'd16) ? 2'd1 : (depth == 16'd24) ? 2'd2 : 2'd3;
  assign fci_inc = 16'(fci) + 16'd1;
  assign may_complete = (phase == PH_DATA) && (sbi == nb1) && (fci_inc >= chans);
  assign byte_in.ready = !occ.status_pend && !(occ.frame_pend && may_complete);
  assign accept = byte_in.valid && byte_in.ready;
  assign asm_full = asm_word | ({24'h0, b} << {sbi, 3'b000});

  wse_conv u_conv (
    .raw(asm_full),
    .depth(depth),
    .is_float(is_float),
    .q31(conv)
  );

  always_comb begin
    phase_next = phase;
    pos_next = pos;
    tag_next = tag;
    len_next = len;
    fmt_tag_next = fmt_tag;
    chans_next = chans;
    rate_next = rate;
    depth_next = depth;
    is_float_next = is_float;
    guid_ok_next = guid_ok;
    asm_word_next = asm_word;
    sbi_next = sbi;
    fci_next = fci;
    store_we = 1'b0;
    stat_v = 1'b0;
    stat_code = ST_OK;
    frm_v = 1'b0;
    bad = 1'b0;
    len_base = len;

    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          if (pos < 32'd4 || (pos >= 32'd8 && pos < 32'd12)) begin
            bad = (b != hdr_byte(pos[3:0]));
          end
          if (bad) begin
            stat_v = 1'b1;
            stat_code = ST_BAD_HEADER;
          end else begin
            pos_next = pos + 32'd1;
            if (pos_next >= 32'd12) begin
              phase_next = PH_CHUNK_HDR;
              pos_next = '0;
            end
          end
        end
        PH_CHUNK_HDR: begin
          len_base = (pos == 32'd0) ? 32'd0 : len;
          if (pos < 32'd4) begin
            tag_next = {tag[23:0], b};
            len_next = len_base;
          end else begin
            len_next = len_base | ({24'h0, b} << {pos[1:0], 3'b000});
          end
          pos_next = pos + 32'd1;
          if (pos == 32'd7) begin
            pos_next = '0;
            if (tag_next == TAG_FMT) begin
              if (len_next < 32'd16) begin
                stat_v = 1'b1;
                stat_code = ST_BAD_CHAN;
              end else begin
                phase_next = PH_FMT;
              end
            end else if (tag_next == TAG_DATA) begin
              priority if (depth != 16'd16 && depth != 16'd24 && depth != 16'd32) begin
                stat_v = 1'b1;
                stat_code = ST_BAD_DEPTH;
              end else if (chans == 16'd0 || chans > 16'(MAX_CHANNELS)) begin
                stat_v = 1'b1;
                stat_code = ST_BAD_CHAN;
              end else if (len_next == 32'd0) begin
                stat_v = 1'b1;
                stat_code = ST_OK;
              end else begin
                phase_next = PH_DATA;
                asm_word_next = '0;
                sbi_next = '0;
                fci_next = '0;
              end
            end else if (len_next != 32'd0) begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          priority if (pos == 32'd0) begin
            fmt_tag_next = {8'h00, b};
          end else if (pos == 32'd1) begin
            fmt_tag_next = {b, fmt_tag[7:0]};
            if (fmt_tag_next != FMT_PCM && fmt_tag_next != FMT_FLOAT &&
                fmt_tag_next != FMT_EXT) begin
              stat_v = 1'b1;
              stat_code = ST_BAD_TAG;
            end
          end else if (pos == 32'd2) begin
            chans_next = {8'h00, b};
          end else if (pos == 32'd3) begin
            chans_next = {b, chans[7:0]};
          end else if (pos == 32'd4) begin
            rate_next = {24'h0, b};
          end else if (pos <= 32'd7) begin
            rate_next = rate | ({24'h0, b} << {pos[1:0], 3'b000});
          end else if (pos == 32'd14) begin
            depth_next = {8'h00, b};
          end else if (pos == 32'd15) begin
            depth_next = {b, depth[7:0]};
            is_float_next = (fmt_tag == FMT_FLOAT) ||
                            (depth_next == 16'd32 && fmt_tag == FMT_EXT);
            guid_ok_next = 1'b1;
          end else if (pos >= 32'd24 && pos <= 32'd39 && fmt_tag == FMT_EXT &&
                       len >= 32'd40) begin
            guid_ok_next = guid_ok && (b == guid_byte(pos[3:0] - 4'd8));
            if (pos == 32'd39) begin
              is_float_next = guid_ok_next;
            end
          end else begin
            // reserved / extension bytes are stepped over
          end
          if (!stat_v) begin
            pos_next = pos + 32'd1;
            if (pos_next == len) begin
              phase_next = PH_CHUNK_HDR;
              pos_next = '0;
            end
          end
        end
        PH_SKIP: begin
          pos_next = pos + 32'd1;
          if (pos_next == len) begin
            phase_next = PH_CHUNK_HDR;
            pos_next = '0;
          end
        end
        PH_DATA: begin
          if (sbi == nb1) begin
            store_we = 1'b1;
            asm_word_next = '0;
            sbi_next = '0;
            if (fci_inc >= chans) begin
              frm_v = 1'b1;
              fci_next = '0;
            end else begin
              fci_next = fci + CH_W'(1);
            end
          end else begin
            asm_word_next = asm_full;
            sbi_next = sbi + 2'd1;
          end
          pos_next = pos + 32'd1;
          if (pos_next == len) begin
            stat_v = 1'b1;
            stat_code = ST_OK;
          end
        end
        default: begin
        end
      endcase

      if (stat_v) begin
        phase_next = PH_SINK;
      end

      if (byte_in.last_byte && phase_next != PH_SINK) begin
        stat_v = 1'b1;
        priority if (phase_next == PH_HEADER) begin
          stat_code = ST_BAD_HEADER;
        end else if (phase_next == PH_DATA) begin
          stat_code = ST_OK;
        end else begin
          stat_code = ST_NO_DATA;
        end
      end
    end

    evt.frame_valid = frm_v;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      evt.frame[i] = (store_we && fci == CH_W'(i)) ? conv : frame_store[i];
    end
    evt.frame_count = chans[CNT_W-1:0];
    evt.status_valid = stat_v;
    evt.status_code = stat_code;
    evt.sample_rate = rate_next;
    evt.channel_count = chans_next;
    evt.bits_per_sample = depth_next;
    evt.float_format = is_float_next && (depth_next == 16'd32);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && byte_in.last_byte)) begin
      phase <= PH_HEADER;
      pos <= '0;
      tag <= '0;
      len <= '0;
      fmt_tag <= FMT_PCM;
      chans <= 16'd1;
      rate <= DEF_RATE;
      depth <= 16'd16;
      is_float <= 1'b0;
      guid_ok <= 1'b1;
      asm_word <= '0;
      sbi <= '0;
      fci <= '0;
    end else begin
      phase <= phase_next;
      pos <= pos_next;
      tag <= tag_next;
      len <= len_next;
      fmt_tag <= fmt_tag_next;
      chans <= chans_next;
      rate <= rate_next;
      depth <= depth_next;
      is_float <= is_float_next;
      guid_ok <= guid_ok_next;
      asm_word <= asm_word_next;
      sbi <= sbi_next;
      fci <= fci_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      frame_store[fci] <= conv;
    end
  end

endmodule

### src/wse_emit.sv
// Result buffer: holds a finished frame and a status, sends them one item a cycle while ready.
`timescale 1ns / 1ps
module wse_emit import wse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  evt_t     evt,
  output occ_t     occ,
  wse_out_if.source result
);

  logic        frame_pend;
  logic        status_pend;
  frame_t      frame_buf;
  logic [CNT_W-1:0] cnt;
  logic [CH_W-1:0]  idx;
  logic [2:0]  code;
  logic [31:0] rate;
  logic [15:0] chans;
  logic [15:0] depth;
  logic        flt;
  logic        pop;
  logic        last_of_frame;

  assign occ.frame_pend = frame_pend;
  assign occ.status_pend = status_pend;
  assign pop = result.valid && result.ready;
  assign last_of_frame = (CNT_W'(idx) + CNT_W'(1)) == cnt;

  assign result.valid = frame_pend || status_pend;
  assign result.kind = frame_pend ? KIND_SAMPLE : (code == ST_OK ? KIND_DONE : KIND_ERROR);
  assign result.sample_value = frame_pend ? frame_buf[idx] : 32'sd0;
  assign result.channel_index = frame_pend ? 3'(idx) : 3'd0;
  assign result.frame_end = frame_pend && last_of_frame;
  assign result.status_code = frame_pend ? ST_OK : code;
  assign result.sample_rate = rate;
  assign result.channel_count = chans;
  assign result.bits_per_sample = depth;
  assign result.float_format = flt;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pend <= 1'b0;
      status_pend <= 1'b0;
      idx <= '0;
    end else begin
      if (pop) begin
        if (frame_pend) begin
          if (last_of_frame) begin
            frame_pend <= 1'b0;
            idx <= '0;
          end else begin
            idx <= idx + CH_W'(1);
          end
        end else begin
          status_pend <= 1'b0;
        end
      end
      // parser holds off new events while the slot they need is taken
      if (evt.frame_valid) begin
        frame_pend <= 1'b1;
        idx <= '0;
      end
      if (evt.status_valid) begin
        status_pend <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt.frame_valid) begin
      frame_buf <= evt.frame;
      cnt <= evt.frame_count;
    end
    if (evt.status_valid) begin
      code <= evt.status_code;
    end
    if (evt.frame_valid || evt.status_valid) begin
      rate <= evt.sample_rate;
      chans <= evt.channel_count;
      depth <= evt.bits_per_sample;
      flt <= evt.float_format;
    end
  end

endmodule

### src/wav_stream_sample_extractor.sv
// Top level of the WAV byte-stream sample extractor.
//
//   port     dir   carries
//   byte_in  sink  data_byte, last_byte: one file byte per item
//   result   src   kind, sample_value, channel_index, frame_end, status_code, fmt fields
//
// One byte is taken per cycle; the parser registers are updated in the accepting cycle.
// A completed frame is copied to the result buffer and sent one sample per cycle while result.ready is high.
// byte_in stalls only when a byte could finish a frame while the previous frame is
// still in the buffer, or while a status item waits.
// rst is synchronous; last_byte rearms the parser after its byte is handled.
`timescale 1ns / 1ps
module wav_stream_sample_extractor import wse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  wse_in_if.sink    byte_in,
  wse_out_if.source result
);

  evt_t evt;
  occ_t occ;

  wse_parser u_parser (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_in),
    .occ(occ),
    .evt(evt)
  );

  wse_emit u_emit (
    .clk(clk),
    .rst(rst),
    .evt(evt),
    .occ(occ),
    .result(result)
  );

endmodule

### src/wse_checker.sv
// Port-level checks for the WAV sample extractor, bound to the top level.
`timescale 1ns / 1ps
module wse_checker import wse_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [31:0] sample_value,
  input logic [2:0]  channel_index,
  input logic [2:0]  status_code
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_SAMPLE || kind == KIND_DONE || kind == KIND_ERROR))
    else $error("illegal result kind");

  a_sample_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_SAMPLE |-> status_code == ST_OK)
    else $error("sample item with status code");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_SAMPLE |-> sample_value == 32'd0 && channel_index == 3'd0)
    else $error("status item carries sample data");

endmodule

bind wav_stream_sample_extractor wse_checker u_wse_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .kind(result.kind),
  .sample_value(result.sample_value),
  .channel_index(result.channel_index),
  .status_code(result.status_code)
);
